// ===== src/rdiv96_pkg.sv =====
// Package for the 96-bit restoring divider.
// Widths, payload structs, sequencer states and the step unit's result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdiv96_pkg;

    localparam int C_LO_W  = 64;
    localparam int C_HI_W  = 32;
    localparam int C_WIDTH = C_LO_W + C_HI_W;
    localparam int C_CNT_W = $clog2(C_WIDTH);

    typedef struct packed {
        logic [C_LO_W-1:0] dividend_low;
        logic [C_HI_W-1:0] dividend_high;
        logic [C_LO_W-1:0] divisor_low;
        logic [C_HI_W-1:0] divisor_high;
    } t_div_in;

    typedef struct packed {
        logic [C_LO_W-1:0] quotient_low;
        logic [C_HI_W-1:0] quotient_high;
        logic [C_LO_W-1:0] remainder_low;
        logic [C_HI_W-1:0] remainder_high;
        logic              divide_by_zero;
    } t_div_out;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [C_WIDTH-1:0] rem;
        logic               qbit;
        logic               seen;
    } t_step_res;

endpackage

`default_nettype wire

// ===== src/restoring_divider_96bit.sv =====
// Top level of the 96-bit unsigned restoring divider: sequencer and operand registers.
// Depends on rdiv96_pkg and rdiv96_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input: drive i_in and raise start; the beat is taken at a clock edge with
//   start high and busy low. busy then stays high while the division runs.
//   Output: o_result is valid for exactly one cycle, marked by o_done. There
//   is no back-pressure; the receiver must capture it in that cycle.
// Timing
//   One quotient bit per cycle through a single 97-bit subtract/compare unit,
//   so 96 iterations. o_done is high in the cycle after the last iteration
//   edge. busy falls together with o_done, so a new beat can be taken in the
//   strobe cycle.
// Zero divisor
//   divide_by_zero is set, the remainder is the dividend and the quotient has
//   ones from bit 0 up to the dividend's highest set bit.
// Reset
//   Synchronous, active low: returns to idle, drops busy and o_done; any
//   division in progress is abandoned.
module restoring_divider_96bit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rdiv96_pkg::t_div_in  i_in,
    output logic                      o_done,
    output rdiv96_pkg::t_div_out      o_result
);
    import rdiv96_pkg::*;

    localparam logic [C_CNT_W-1:0] C_LAST = C_CNT_W'(C_WIDTH - 1);

    t_state             r_state, n_state;
    logic [C_CNT_W-1:0] r_cnt,   n_cnt;
    logic               r_done,  n_done;
    logic [C_WIDTH-1:0] r_num,   n_num;
    logic [C_WIDTH-1:0] r_den,   n_den;
    logic [C_WIDTH-1:0] r_rem,   n_rem;
    logic [C_WIDTH-1:0] r_quo,   n_quo;
    logic               r_dz,    n_dz;
    logic               r_seen,  n_seen;

    t_step_res          step;

    rdiv96_step u_step (
        .i_rem  (r_rem),
        .i_den  (r_den),
        .i_bit  (r_num[C_WIDTH-1]),
        .i_dz   (r_dz),
        .i_seen (r_seen),
        .o_res  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dz   <= n_dz;
        r_seen <= n_seen;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dz    = r_dz;
        n_seen  = r_seen;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_num   = {i_in.dividend_high, i_in.dividend_low};
                    n_den   = {i_in.divisor_high, i_in.divisor_low};
                    n_rem   = '0;
                    n_quo   = '0;
                    n_dz    = (n_den == '0);
                    n_seen  = 1'b0;
                    n_cnt   = C_LAST;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_num  = {r_num[C_WIDTH-2:0], 1'b0};
                n_rem  = step.rem;
                n_quo  = {r_quo[C_WIDTH-2:0], step.qbit};
                n_seen = step.seen;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy   = (r_state == ST_RUN);
    assign o_done = r_done;

    // working registers hold the result until the next beat is loaded
    always_comb begin
        o_result.quotient_low   = r_quo[C_LO_W-1:0];
        o_result.quotient_high  = r_quo[C_WIDTH-1:C_LO_W];
        o_result.remainder_low  = r_rem[C_LO_W-1:0];
        o_result.remainder_high = r_rem[C_WIDTH-1:C_LO_W];
        o_result.divide_by_zero = r_dz;
    end

endmodule

`default_nettype wire

// ===== src/rdiv96_step.sv =====
// One radix-2 restoring step: shift in a dividend bit, trial subtract, restore.
// Depends on rdiv96_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdiv96_step (
    input  wire logic [rdiv96_pkg::C_WIDTH-1:0] i_rem,
    input  wire logic [rdiv96_pkg::C_WIDTH-1:0] i_den,
    input  wire logic                           i_bit,
    input  wire logic                           i_dz,
    input  wire logic                           i_seen,
    output rdiv96_pkg::t_step_res               o_res
);
    import rdiv96_pkg::*;

    logic [C_WIDTH:0]   shifted;
    logic [C_WIDTH+1:0] diff;
    logic               ge;

    always_comb begin
        shifted = {i_rem, i_bit};
        diff    = {1'b0, shifted} - {2'b00, i_den};
        ge      = ~diff[C_WIDTH+1];
        // result always fits 96 bits: below the divisor, or the dividend prefix when it is zero
        o_res.rem  = ge ? diff[C_WIDTH-1:0] : shifted[C_WIDTH-1:0];
        o_res.seen = i_seen | i_bit;
        // zero divisor: ones from the dividend's top set bit downward
        o_res.qbit = i_dz ? (i_seen | i_bit) : ge;
    end

endmodule

`default_nettype wire

// ===== src/rdiv96_chk.sv =====
// Port-level checker for restoring_divider_96bit, with its bind statement.
// Depends on rdiv96_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdiv96_chk (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_done,
    input wire rdiv96_pkg::t_div_out o_result
);
    import rdiv96_pkg::*;

    localparam int C_LAT = C_WIDTH + 1;

    logic zero_den_rem;
    assign zero_den_rem = o_result.divide_by_zero
                          && (o_result.quotient_low[0] == 1'b0)
                          && ((o_result.remainder_low != '0)
                              || (o_result.remainder_high != '0));

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted beat");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##C_LAT o_done)
        else $error("result strobe missing at the expected latency");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $fell(busy))
        else $error("result strobe not aligned with end of busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // zero divisor: a nonzero dividend always gives quotient bit 0 set
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !zero_den_rem)
        else $error("zero-divisor quotient inconsistent with remainder");

endmodule

bind restoring_divider_96bit rdiv96_chk u_rdiv96_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
